FILE: design/i2cm_pkg.sv
// shared types and codes for the i2c register access master
// no dependencies; used by i2cm_step and i2c_register_access_master

package i2cm_pkg;

    localparam logic [15:0] PHASE_TICKS_RESET = 16'd100;
    localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;
    localparam logic [2:0]  NACK_SLOTS        = 3'd3;

    // request codes carried in func
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    // unassigned code, behaves as a plain tick
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_START_A  = 4'd1,
        ST_START_B  = 4'd2,
        ST_TX_LOW   = 4'd3,
        ST_TX_DATA  = 4'd4,
        ST_TX_HIGH  = 4'd5,
        ST_ACK_LOW  = 4'd6,
        ST_ACK_REL  = 4'd7,
        ST_ACK_HIGH = 4'd8,
        ST_ACK_TAIL = 4'd9,
        ST_RX_HIGH  = 4'd10,
        ST_RX_LOW   = 4'd11,
        ST_STOP_A   = 4'd12,
        ST_STOP_B   = 4'd13,
        ST_STOP_C   = 4'd14,
        ST_STOP_D   = 4'd15
    } i2cm_step_t;

    typedef struct packed {
        i2cm_step_t  step;
        logic [3:0]  bit_cnt;
        logic [7:0]  shift;
        logic [15:0] delay;
        logic [2:0]  byte_idx;
        logic [7:0]  dev_addr;
        logic [7:0]  reg_addr;
        logic [7:0]  wr_data;
        logic        read_mode;
        logic [7:0]  cap_byte;
        logic [3:0]  nack;
        logic        scl;
        logic        sda;
    } i2cm_state_t;

    // idle sequencer with both lines released
    localparam i2cm_state_t STATE_RESET = '{
        step:      ST_IDLE,
        bit_cnt:   4'd0,
        shift:     8'd0,
        delay:     16'd0,
        byte_idx:  3'd0,
        dev_addr:  8'd0,
        reg_addr:  8'd0,
        wr_data:   8'd0,
        read_mode: 1'b0,
        cap_byte:  8'd0,
        nack:      4'd0,
        scl:       1'b1,
        sda:       1'b1
    };

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rd_byte;
        logic [3:0] nack;
    } i2cm_res_t;

endpackage

FILE: design/i2cm_step.sv
// next-state and result logic for one bus tick of the i2c master sequencer
// depends on i2cm_pkg

module i2cm_step
    import i2cm_pkg::*;
(
    input  i2cm_state_t state,
    input  logic [15:0] phase_ticks,
    input  logic [1:0]  func,
    input  logic [7:0]  slave_addr,
    input  logic [7:0]  reg_addr,
    input  logic [7:0]  write_data,
    input  logic        sda_in,
    output i2cm_state_t state_next,
    output i2cm_res_t   res_next
);

    logic [15:0] ptick;

    // a zero setting behaves as one tick
    assign ptick = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;

    function automatic i2cm_state_t enter_phase(input i2cm_state_t s_in,
                                                input i2cm_step_t  nxt,
                                                input logic [15:0] dly);
        i2cm_state_t s;
        s       = s_in;
        s.step  = nxt;
        s.delay = dly;
        case (nxt)
            ST_START_A:  begin s.scl = 1'b1; s.sda = 1'b1; end
            ST_START_B:  s.sda = 1'b0;
            ST_TX_LOW:   s.scl = 1'b0;
            ST_TX_DATA:
            begin
                s.sda   = s.shift[7];
                s.shift = {s.shift[6:0], 1'b0};
            end
            ST_TX_HIGH:  s.scl = 1'b1;
            ST_ACK_LOW:  s.scl = 1'b0;
            ST_ACK_REL:  s.sda = 1'b1;
            ST_ACK_HIGH: s.scl = 1'b1;
            ST_ACK_TAIL: s.scl = 1'b0;
            ST_RX_HIGH:  s.scl = 1'b1;
            ST_RX_LOW:   s.scl = 1'b0;
            ST_STOP_A:   s.scl = 1'b0;
            ST_STOP_B:   s.sda = 1'b0;
            ST_STOP_C:   s.scl = 1'b1;
            ST_STOP_D:   s.sda = 1'b1;
            default:     s.step = nxt;
        endcase
        return s;
    endfunction

    function automatic i2cm_state_t begin_byte(input i2cm_state_t s_in,
                                               input logic [7:0]  b,
                                               input logic [15:0] dly);
        i2cm_state_t s;
        s         = s_in;
        s.shift   = b;
        s.bit_cnt = 4'd0;
        return enter_phase(s, ST_TX_LOW, dly);
    endfunction

    // pick what follows an acknowledged (or flagged) byte
    function automatic i2cm_state_t after_ack(input i2cm_state_t s_in,
                                              input logic [15:0] dly);
        i2cm_state_t s;
        logic [2:0]  idx;
        s          = s_in;
        idx        = s.byte_idx;
        s.byte_idx = idx + 3'd1;
        if (idx == 3'd0)
        begin
            s = begin_byte(s, s.reg_addr, dly);
        end
        else if (!s.read_mode)
        begin
            if (idx == 3'd1)
                s = begin_byte(s, s.wr_data, dly);
            else
                s = enter_phase(s, ST_STOP_A, dly);
        end
        else if (idx == 3'd1)
        begin
            s = enter_phase(s, ST_START_A, dly);
        end
        else if (idx == 3'd2)
        begin
            s.bit_cnt = 4'd0;
            s.shift   = 8'd0;
            s         = enter_phase(s, ST_RX_HIGH, dly);
        end
        else
        begin
            s = enter_phase(s, ST_STOP_A, dly);
        end
        return s;
    endfunction

    always_comb
    begin
        i2cm_state_t s;
        logic        done;
        s    = state;
        done = 1'b0;
        if (s.step == ST_IDLE)
        begin
            if (func == FUNC_WRITE || func == FUNC_READ)
            begin
                s.dev_addr  = slave_addr;
                s.reg_addr  = reg_addr;
                s.wr_data   = write_data;
                s.read_mode = (func == FUNC_READ);
                s.nack      = 4'd0;
                s.byte_idx  = 3'd0;
                s.bit_cnt   = 4'd0;
                s           = enter_phase(s, ST_START_A, ptick);
            end
        end
        else
        begin
            s.delay = s.delay - 16'd1;
            if (s.delay == 16'd0)
            begin
                case (s.step)
                    ST_START_A:  s = enter_phase(s, ST_START_B, ptick);
                    ST_START_B:
                    begin
                        // repeated start sends the read address
                        if (s.byte_idx == 3'd0)
                            s = begin_byte(s, s.dev_addr, ptick);
                        else
                            s = begin_byte(s, s.dev_addr + 8'd1, ptick);
                    end
                    ST_TX_LOW:   s = enter_phase(s, ST_TX_DATA, ptick);
                    ST_TX_DATA:  s = enter_phase(s, ST_TX_HIGH, ptick);
                    ST_TX_HIGH:
                    begin
                        s.bit_cnt = s.bit_cnt + 4'd1;
                        if (s.bit_cnt < BITS_PER_BYTE)
                            s = enter_phase(s, ST_TX_LOW, ptick);
                        else
                            s = enter_phase(s, ST_ACK_LOW, ptick);
                    end
                    ST_ACK_LOW:  s = enter_phase(s, ST_ACK_REL, ptick);
                    ST_ACK_REL:  s = enter_phase(s, ST_ACK_HIGH, ptick);
                    ST_ACK_HIGH:
                    begin
                        if (sda_in)
                        begin
                            // no ack: flag it and move on without a tail phase
                            s.scl = 1'b0;
                            if (s.byte_idx < NACK_SLOTS)
                                s.nack[s.byte_idx[1:0]] = 1'b1;
                            s = after_ack(s, ptick);
                        end
                        else
                        begin
                            s = enter_phase(s, ST_ACK_TAIL, ptick);
                        end
                    end
                    ST_ACK_TAIL: s = after_ack(s, ptick);
                    ST_RX_HIGH:
                    begin
                        s.shift = {s.shift[6:0], sda_in};
                        s       = enter_phase(s, ST_RX_LOW, ptick);
                    end
                    ST_RX_LOW:
                    begin
                        s.bit_cnt = s.bit_cnt + 4'd1;
                        if (s.bit_cnt < BITS_PER_BYTE)
                        begin
                            s = enter_phase(s, ST_RX_HIGH, ptick);
                        end
                        else
                        begin
                            s.cap_byte = s.shift;
                            s          = enter_phase(s, ST_ACK_LOW, ptick);
                        end
                    end
                    ST_STOP_A:   s = enter_phase(s, ST_STOP_B, ptick);
                    ST_STOP_B:   s = enter_phase(s, ST_STOP_C, ptick);
                    ST_STOP_C:   s = enter_phase(s, ST_STOP_D, ptick);
                    ST_STOP_D:
                    begin
                        s.step  = ST_IDLE;
                        s.delay = 16'd0;
                        done    = 1'b1;
                    end
                    default:
                    begin
                        s.step  = ST_IDLE;
                        s.delay = 16'd0;
                    end
                endcase
            end
        end
        state_next       = s;
        res_next.scl     = s.scl;
        res_next.sda     = s.sda;
        res_next.busy    = (s.step != ST_IDLE);
        res_next.done    = done;
        res_next.rd_byte = s.cap_byte;
        res_next.nack    = s.nack;
    end

endmodule

FILE: design/i2c_register_access_master.sv
// i2c register access master: one timebase tick beat in, one result beat out
// latency: the result of a tick beat is presented on the cycle after it is accepted
// throughput: one tick beat per cycle unless stalled; sequencer state and result update together
// tick_stall is high only while a result waits and res_stall holds it
// reset (rst_n low, asynchronous): sequencer idle, scl/sda released, phase_ticks = 100
// depends on i2cm_pkg and i2cm_step

module i2c_register_access_master
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        phase_ticks_we,
    input  logic [15:0] phase_ticks_wdata,
    input  logic        tick_valid,
    output logic        tick_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  slave_addr,
    input  logic [7:0]  reg_addr,
    input  logic [7:0]  write_data,
    input  logic        sda_in,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        scl_level,
    output logic        sda_level,
    output logic        busy_res,
    output logic        done_res,
    output logic [7:0]  read_byte,
    output logic [3:0]  nack_flags
);

    logic [15:0] phase_ticks_reg;
    i2cm_state_t state_reg;
    i2cm_state_t state_next;
    i2cm_res_t   res_reg;
    i2cm_res_t   res_next;
    logic        res_valid_reg;
    logic        tick_fire;

    i2cm_step u_step (
        .state       (state_reg),
        .phase_ticks (phase_ticks_reg),
        .func        (func),
        .slave_addr  (slave_addr),
        .reg_addr    (reg_addr),
        .write_data  (write_data),
        .sda_in      (sda_in),
        .state_next  (state_next),
        .res_next    (res_next)
    );

    // accept while the result register is empty or draining this cycle
    assign tick_stall = res_valid_reg & res_stall;
    assign tick_fire  = tick_valid & ~tick_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
        end
        else if (phase_ticks_we)
        begin
            phase_ticks_reg <= phase_ticks_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= STATE_RESET;
            res_valid_reg       <= 1'b0;
        end
        else
        begin
            if (tick_fire)
            begin
                state_reg     <= state_next;
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid  = res_valid_reg;
    assign scl_level  = res_reg.scl;
    assign sda_level  = res_reg.sda;
    assign busy_res   = res_reg.busy;
    assign done_res   = res_reg.done;
    assign read_byte  = res_reg.rd_byte;
    assign nack_flags = res_reg.nack;

endmodule
